@@ rtl/core/rpose_pkg.sv @@
package rpose_pkg;

  // Pipeline dimensions
  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int GAIN_Q30      = 652032874;

  // Field and datapath widths
  localparam int POS_W  = 32;
  localparam int HEAD_W = 16;
  localparam int CW     = FRAC_BITS + 3;   // cosine / sine accumulators
  localparam int ZW     = 33;              // residual angle, 2^32 = full turn
  localparam int DW     = POS_W + 1;       // exact position difference
  localparam int PRW    = CW + DW;         // one product
  localparam int SW     = PRW + 2;         // sum of two products, negated
  localparam int SIDX_W = 5;               // index into the arctangent table

  localparam logic signed [HEAD_W-1:0] QUARTER_TURN = HEAD_W'(16384);
  localparam logic [HEAD_W-1:0]        HALF_TURN    = HEAD_W'(32768);

  // Inverse CORDIC gain, reduced from Q30 with rounding half up
  localparam logic signed [CW-1:0] X0 =
    CW'((GAIN_Q30 + (1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));

  // Data handed from cell to cell
  typedef struct packed {
    logic signed [CW-1:0]     x;
    logic signed [CW-1:0]     y;
    logic signed [ZW-1:0]     z;
    logic signed [DW-1:0]     dx;
    logic signed [DW-1:0]     dy;
    logic                     neg;
    logic signed [HEAD_W-1:0] rel_heading;
  } cell_t;

  // One result beat
  typedef struct packed {
    logic signed [POS_W-1:0]  rel_x;
    logic signed [POS_W-1:0]  rel_y;
    logic signed [HEAD_W-1:0] rel_heading;
    logic                     saturated;
  } rel_out_t;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic signed [ZW-1:0] atan_entry(input logic [SIDX_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = ZW'(32'h20000000);
      5'd1:    v = ZW'(32'h12E4051E);
      5'd2:    v = ZW'(32'h09FB385B);
      5'd3:    v = ZW'(32'h051111D4);
      5'd4:    v = ZW'(32'h028B0D43);
      5'd5:    v = ZW'(32'h0145D7E1);
      5'd6:    v = ZW'(32'h00A2F61E);
      5'd7:    v = ZW'(32'h00517C55);
      5'd8:    v = ZW'(32'h0028BE53);
      5'd9:    v = ZW'(32'h00145F2F);
      5'd10:   v = ZW'(32'h000A2F98);
      5'd11:   v = ZW'(32'h000517CC);
      5'd12:   v = ZW'(32'h00028BE6);
      5'd13:   v = ZW'(32'h000145F3);
      5'd14:   v = ZW'(32'h0000A2FA);
      5'd15:   v = ZW'(32'h0000517D);
      5'd16:   v = ZW'(32'h000028BE);
      5'd17:   v = ZW'(32'h0000145F);
      5'd18:   v = ZW'(32'h00000A30);
      5'd19:   v = ZW'(32'h00000518);
      5'd20:   v = ZW'(32'h0000028C);
      5'd21:   v = ZW'(32'h00000146);
      5'd22:   v = ZW'(32'h000000A3);
      5'd23:   v = ZW'(32'h00000051);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/rpose_if.sv @@
interface rpose_in_if;
  import rpose_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  ref_x;
  logic signed [POS_W-1:0]  ref_y;
  logic signed [HEAD_W-1:0] ref_heading;
  logic signed [POS_W-1:0]  target_x;
  logic signed [POS_W-1:0]  target_y;
  logic signed [HEAD_W-1:0] target_heading;

  modport source(output valid, ref_x, ref_y, ref_heading, target_x, target_y,
                 target_heading, input ready);
  modport sink(input valid, ref_x, ref_y, ref_heading, target_x, target_y,
               target_heading, output ready);
endinterface

interface rpose_out_if;
  import rpose_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  rel_x;
  logic signed [POS_W-1:0]  rel_y;
  logic signed [HEAD_W-1:0] rel_heading;
  logic                     saturated;

  modport source(output valid, rel_x, rel_y, rel_heading, saturated, input ready);
  modport sink(input valid, rel_x, rel_y, rel_heading, saturated, output ready);
endinterface

@@ rtl/core/rpose_cell.sv @@
module rpose_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [rpose_pkg::SIDX_W-1:0]   stage,
  input  logic                           valid_i,
  input  rpose_pkg::cell_t               d_i,
  output logic                           valid_o,
  output rpose_pkg::cell_t               d_o
);
  import rpose_pkg::*;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] angle;
  cell_t                d_next;

  // One micro-rotation; the shift amount is tied off per cell
  always_comb begin
    xs     = d_i.x >>> stage;
    ys     = d_i.y >>> stage;
    angle  = atan_entry(stage);
    d_next = d_i;
    if (!d_i.z[ZW-1]) begin
      d_next.x = d_i.x - ys;
      d_next.y = d_i.y + xs;
      d_next.z = d_i.z - angle;
    end else begin
      d_next.x = d_i.x + ys;
      d_next.y = d_i.y - xs;
      d_next.z = d_i.z + angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_next;
    end
  end

endmodule

@@ rtl/core/rpose_tail.sv @@
module rpose_tail (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  valid_i,
  input  rpose_pkg::cell_t      d_i,
  output logic                  valid_o,
  output rpose_pkg::rel_out_t   res_o
);
  import rpose_pkg::*;

  localparam logic signed [SW-1:0] HALF    = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_MAX = SW'(32'sh7FFFFFFF);
  localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

  // Multiply stage
  logic                     m_valid;
  logic signed [PRW-1:0]    p_cdx, p_sdy, p_cdy, p_sdx;
  logic                     m_neg;
  logic signed [HEAD_W-1:0] m_head;

  // Sum stage
  logic                     a_valid;
  logic signed [SW-1:0]     sum_x, sum_y;
  logic signed [HEAD_W-1:0] a_head;

  logic signed [SW-1:0]     sum_x_next, sum_y_next;
  logic signed [SW-1:0]     rx, ry;
  logic                     sat_x, sat_y;
  rel_out_t                 res_next;

  always_comb begin
    if (m_neg) begin
      sum_x_next = -SW'(p_cdx) - SW'(p_sdy);
      sum_y_next = -SW'(p_cdy) + SW'(p_sdx);
    end else begin
      sum_x_next = SW'(p_cdx) + SW'(p_sdy);
      sum_y_next = SW'(p_cdy) - SW'(p_sdx);
    end
  end

  // Round half up, then clip to 32 bits
  always_comb begin
    rx    = (sum_x + HALF) >>> FRAC_BITS;
    ry    = (sum_y + HALF) >>> FRAC_BITS;
    sat_x = (rx > SAT_MAX) || (rx < SAT_MIN);
    sat_y = (ry > SAT_MAX) || (ry < SAT_MIN);
    res_next.rel_x = (rx > SAT_MAX) ? POS_W'(SAT_MAX) :
                     (rx < SAT_MIN) ? POS_W'(SAT_MIN) : POS_W'(rx);
    res_next.rel_y = (ry > SAT_MAX) ? POS_W'(SAT_MAX) :
                     (ry < SAT_MIN) ? POS_W'(SAT_MIN) : POS_W'(ry);
    res_next.rel_heading = a_head;
    res_next.saturated   = sat_x | sat_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      a_valid <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      m_valid <= valid_i;
      a_valid <= m_valid;
      valid_o <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_cdx  <= d_i.x * d_i.dx;
      p_sdy  <= d_i.y * d_i.dy;
      p_cdy  <= d_i.x * d_i.dy;
      p_sdx  <= d_i.y * d_i.dx;
      m_neg  <= d_i.neg;
      m_head <= d_i.rel_heading;
      sum_x  <= sum_x_next;
      sum_y  <= sum_y_next;
      a_head <= m_head;
      res_o  <= res_next;
    end
  end

endmodule

@@ rtl/core/planar_relative_pose_top.sv @@
// Planar relative pose: expresses a target pose in the frame of a reference
// pose. rel_x/rel_y are the position difference rotated by minus the
// reference heading (Q16.16, clipped to 32 bits, clipping flags saturated);
// rel_heading is the heading difference modulo 2^16.
//
// Channels: pose (sink) takes one reference/target pair per beat; rel
// (source) gives one result beat per pair, in order. Both are valid/ready.
//
// Throughput: one pair per clock while the output queue has room. Path
// from the accepting edge to rel.valid: entry register, one cell per CORDIC
// micro-rotation, multiply, sum, round/clip, then the output queue.
//
// The whole pipeline advances as one while the two-entry output queue has
// room; when the receiver stalls, results collect there and pose.ready
// drops only once the queue is full, so no beat is lost or repeated.
// Reset clears all valid bits and empties the queue, and pose.ready stays
// low while rst is high; no state otherwise.
module planar_relative_pose_top (
  input  logic              clk,
  input  logic              rst,
  rpose_in_if.sink          pose,
  rpose_out_if.source       rel
);
  import rpose_pkg::*;

  logic     en;
  logic     chain_valid [0:CORDIC_STAGES];
  cell_t    chain       [0:CORDIC_STAGES];
  cell_t    entry_next;
  logic     entry_valid;
  cell_t    entry;
  logic     t_valid;
  rel_out_t t_res;

  // Output queue
  rel_out_t fifo_mem [0:1];
  logic     wr_ptr, rd_ptr;
  logic [1:0] fcount;
  logic     push, pop;

  logic signed [HEAD_W-1:0] angle;
  logic                     neg;

  // Advance every stage together while the queue can take one more beat
  assign en         = (fcount != 2'd2);
  assign pose.ready = en & ~rst;

  // Fold headings beyond a quarter turn by a half turn; negate at the end
  always_comb begin
    neg   = (pose.ref_heading > QUARTER_TURN) || (pose.ref_heading < -QUARTER_TURN);
    angle = neg ? (pose.ref_heading + HALF_TURN) : pose.ref_heading;
    entry_next.x           = X0;
    entry_next.y           = '0;
    entry_next.z           = ZW'({angle, 16'h0000}) | {ZW{angle[HEAD_W-1]}} << 32;
    entry_next.dx          = DW'(pose.target_x) - DW'(pose.ref_x);
    entry_next.dy          = DW'(pose.target_y) - DW'(pose.ref_y);
    entry_next.neg         = neg;
    entry_next.rel_heading = pose.target_heading - pose.ref_heading;
  end

  // Entry register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (en) begin
      entry_valid <= pose.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry <= entry_next;
    end
  end

  assign chain_valid[0] = entry_valid;
  assign chain[0]       = entry;

  // Row of CORDIC cells, one micro-rotation each
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    rpose_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .stage   (SIDX_W'(g)),
      .valid_i (chain_valid[g]),
      .d_i     (chain[g]),
      .valid_o (chain_valid[g+1]),
      .d_o     (chain[g+1])
    );
  end

  // Multiply, sum, round and clip
  rpose_tail u_tail (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid_i (chain_valid[CORDIC_STAGES]),
    .d_i     (chain[CORDIC_STAGES]),
    .valid_o (t_valid),
    .res_o   (t_res)
  );

  // Two-entry output queue: holds results while the receiver stalls
  assign push = en & t_valid;
  assign pop  = rel.valid & rel.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fcount <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fcount <= fcount + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= t_res;
    end
  end

  assign rel.valid       = (fcount != 2'd0);
  assign rel.rel_x       = fifo_mem[rd_ptr].rel_x;
  assign rel.rel_y       = fifo_mem[rd_ptr].rel_y;
  assign rel.rel_heading = fifo_mem[rd_ptr].rel_heading;
  assign rel.saturated   = fifo_mem[rd_ptr].saturated;

endmodule
